### design/igam_pkg.sv
`default_nettype none
package igam_pkg;

   localparam int ValueBits = 32;
   localparam logic [ValueBits-1:0] ValueMax = 32'h4000_0000;
   localparam int TopBit = 30;
   localparam int CodeBits = 2 * TopBit + 1;
   localparam int LenBits = $clog2(CodeBits + 1);
   localparam int ByteBits = 8;
   localparam int AccBits = CodeBits + ByteBits - 1;
   localparam int CntBits = $clog2(AccBits + 1);
   localparam int WordBytes = 8;
   localparam int BmodBits = $clog2(WordBytes);

   typedef struct packed {
      logic                ok;
      logic                last;
      logic [CodeBits-1:0] code;
      logic [LenBits-1:0]  len;
   } igam_item_type;

   // Interleave pairs (0, value bit) from the LSB up, then the closing 1 at the top bit.
   function automatic igam_item_type encode(input logic [ValueBits-1:0] value,
                                            input logic last);
      igam_item_type item;
      logic [TopBit:0] v;
      logic [LenBits-1:0] top;
      item.ok = (value != '0) && (value <= ValueMax);
      item.last = last;
      item.code = '0;
      v = value[TopBit:0];
      top = '0;
      for (int k = 0; k < TopBit; k++) begin
         if (v[k]) begin
            top = LenBits'(k);
         end
         if ((v >> (k + 1)) != '0) begin
            item.code[2*k+1] = v[k];
         end else begin
            item.code[2*k] = v[k];
         end
      end
      // nothing sits above the highest bit, so it can only close the code
      if (v[TopBit]) begin
         top = LenBits'(TopBit);
      end
      item.code[2*TopBit] = v[TopBit];
      item.len = LenBits'({top, 1'b1});
      return item;
   endfunction

endpackage
`default_nettype wire

### design/igam_in_reg.sv
`default_nettype none
module igam_in_reg (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [igam_pkg::ValueBits-1:0]  req_tdata,
   input  wire logic                            req_tlast,
   input  wire logic                            take,
   output logic                                 word_valid,
   output logic [igam_pkg::ValueBits-1:0]       word_value,
   output logic                                 word_last
);
   import igam_pkg::*;

   logic                 valid_ff, valid_in;
   logic [ValueBits-1:0] value_ff;
   logic                 last_ff;

   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         value_ff <= req_tdata;
         last_ff  <= req_tlast;
      end
   end

   assign word_valid = valid_ff;
   assign word_value = value_ff;
   assign word_last  = last_ff;

endmodule
`default_nettype wire

### design/igam_code.sv
`default_nettype none
module igam_code (
   input  wire logic [igam_pkg::ValueBits-1:0] value,
   input  wire logic                           last,
   output igam_pkg::igam_item_type             item
);
   import igam_pkg::*;

   assign item = encode(value, last);

endmodule
`default_nettype wire

### design/igam_packer.sv
`default_nettype none
module igam_packer (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            component_mode,
   input  wire logic                            item_valid,
   input  wire igam_pkg::igam_item_type         item,
   output logic                                 take,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [igam_pkg::ByteBits-1:0]        rsp_tdata,
   output logic                                 rsp_tlast,
   output logic                                 rsp_tuser
);
   import igam_pkg::*;

   logic [AccBits-1:0]  acc_ff, acc_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic [BmodBits-1:0] bmod_ff, bmod_in, bmod_step;
   logic                fin_ff, fin_in;
   logic                xtra_ff, xtra_in;
   logic                err_ff, err_in;
   logic                disc_ff, disc_in;
   logic                rsp_valid_ff;
   logic [ByteBits-1:0] rsp_data_ff;
   logic                rsp_last_ff, rsp_err_ff;

   logic                out_free, emit, e_last, e_err, idle_after;
   logic [ByteBits-1:0] e_byte;

   always_comb begin
      out_free = !rsp_valid_ff || rsp_tready;
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      bmod_in  = bmod_ff;
      fin_in   = fin_ff;
      xtra_in  = xtra_ff;
      err_in   = err_ff;
      disc_in  = disc_ff;
      emit     = 1'b0;
      e_byte   = '0;
      e_last   = 1'b0;
      e_err    = 1'b0;
      take     = 1'b0;
      bmod_step = (bmod_ff == BmodBits'(WordBytes - 1)) ? '0 : bmod_ff + 1'b1;

      if (err_ff) begin
         if (out_free) begin
            emit   = 1'b1;
            e_last = 1'b1;
            e_err  = 1'b1;
            err_in = 1'b0;
         end
      end else if (xtra_ff) begin
         if (out_free) begin
            emit    = 1'b1;
            e_last  = 1'b1;
            xtra_in = 1'b0;
         end
      end else if (cnt_ff >= CntBits'(ByteBits) || (fin_ff && cnt_ff != '0)) begin
         if (out_free) begin
            emit   = 1'b1;
            e_byte = acc_ff[ByteBits-1:0];
            acc_in = acc_ff >> ByteBits;
            cnt_in = (cnt_ff >= CntBits'(ByteBits)) ? cnt_ff - CntBits'(ByteBits) : '0;
            if (fin_ff && cnt_in == '0) begin
               // block ends: pad done, maybe append the zero marker word
               fin_in  = 1'b0;
               bmod_in = '0;
               if (!component_mode && bmod_step == '0) begin
                  xtra_in = 1'b1;
               end else begin
                  e_last = 1'b1;
               end
            end else begin
               bmod_in = bmod_step;
            end
         end
      end

      idle_after = !err_in && !xtra_in && !fin_in && (cnt_in < CntBits'(ByteBits));

      if (idle_after && item_valid) begin
         take = 1'b1;
         if (disc_ff) begin
            if (item.last) begin
               disc_in = 1'b0;
            end
         end else if (!item.ok) begin
            err_in  = 1'b1;
            acc_in  = '0;
            cnt_in  = '0;
            bmod_in = '0;
            disc_in = !item.last;
         end else begin
            acc_in = acc_in | (AccBits'(item.code) << cnt_in[2:0]);
            cnt_in = cnt_in + CntBits'(item.len);
            fin_in = item.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         cnt_ff       <= '0;
         bmod_ff      <= '0;
         fin_ff       <= 1'b0;
         xtra_ff      <= 1'b0;
         err_ff       <= 1'b0;
         disc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         bmod_ff <= bmod_in;
         fin_ff  <= fin_in;
         xtra_ff <= xtra_in;
         err_ff  <= err_in;
         disc_ff <= disc_in;
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
      end
      if (out_free && emit) begin
         rsp_data_ff <= e_byte;
         rsp_last_ff <= e_last;
         rsp_err_ff  <= e_err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

`ifndef ASSERT_OFF
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_err_ff |-> rsp_last_ff && rsp_data_ff == '0)
      else $error("error word without end of block or with data");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CntBits'(AccBits))
      else $error("bit count beyond accumulator");
   a_acc_clean: assert property (@(posedge clock) disable iff (reset)
      (acc_ff >> cnt_ff) == '0)
      else $error("stale bits above pending count");
   a_xtra_alone: assert property (@(posedge clock) disable iff (reset)
      xtra_ff |-> cnt_ff == '0 && !fin_ff && !err_ff)
      else $error("marker word pending with data left");
   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      err_ff |-> cnt_ff == '0 && !fin_ff && bmod_ff == '0)
      else $error("error pending with data left");
`endif

endmodule
`default_nettype wire

### design/interleaved_gamma_encoder.sv
`default_nettype none
// Interleaved Elias-gamma encoder.
// req channel: one word per value. req_tdata is the unsigned value (valid 1 to 2^30),
// req_tlast marks the last value of a block. rsp channel: one code byte per word,
// earliest code bit in bit 0; rsp_tlast marks the final byte of a block (after the
// zero padding and, outside component mode, the zero marker byte appended when the
// block's byte count is a multiple of eight); rsp_tuser flags an error word (out of
// range value), which also ends the block; later values up to req_tlast are dropped.
// csr_we/csr_wdata set component_mode; write it only while the block is idle.
// Path: a value is held in the input register, merged into the bit accumulator when
// the packer takes it, and its bytes leave through the output register to rsp.
// Throughput: values that complete no byte are taken one per cycle; otherwise the
// byte-wide output register sets the pace, one byte per cycle while rsp_tready is
// high, up to ten bytes per value.
// A stall on rsp_tready holds the output register; the accumulator still takes values
// until a whole byte waits in it, then the input register fills and req_tready drops.
// Reset clears the accumulator, byte count, discard state and component_mode.
module interleaved_gamma_encoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic        csr_wdata,   // component_mode
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic        req_tlast,   // last_value
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast,   // end_of_block
   output logic             rsp_tuser    // error
);
   import igam_pkg::*;

   logic                 mode_ff;
   logic                 take;
   logic                 word_valid;
   logic [ValueBits-1:0] word_value;
   logic                 word_last;
   igam_item_type        item;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_we) begin
         mode_ff <= csr_wdata;
      end
   end

   igam_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (take),
      .word_valid (word_valid),
      .word_value (word_value),
      .word_last  (word_last)
   );

   igam_code u_code (
      .value (word_value),
      .last  (word_last),
      .item  (item)
   );

   igam_packer u_packer (
      .clock          (clock),
      .reset          (reset),
      .component_mode (mode_ff),
      .item_valid     (word_valid),
      .item           (item),
      .take           (take),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .rsp_tuser      (rsp_tuser)
   );

endmodule
`default_nettype wire

### tb/tb_top.sv
`default_nettype none
module tb_top;

   localparam int SettleCycles = 8;
   localparam int StallLimit = 4000;
   localparam bit ModeMarker = 1'b0;
   localparam bit ModeComponent = 1'b1;

   typedef struct {
      logic [7:0] data;
      logic       eob;
      logic       err;
   } code_word_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_wdata = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;

   // predictor state
   logic [7:0]  acc_bits;
   int          acc_count;
   int          block_bytes;
   bit          dropping;
   bit          comp_mode;

   code_word_type expected_words[$];
   int          fail_count;
   int          values_sent;
   int          words_seen;
   int          error_words;
   bit          src_gaps;
   bit          sink_gaps;
   int          hold_req;
   int          hold_cnt;
   int          gap_cnt;
   int          quiet_cycles;

   interleaved_gamma_encoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at word %0d: %s", words_seen, msg);
      fail_count++;
   endtask

   task automatic emit_word(input logic [7:0] data, input logic err);
      code_word_type w;
      w.data = data;
      w.eob = err;
      w.err = err;
      expected_words.push_back(w);
      block_bytes = (block_bytes + 1) % igam_pkg::WordBytes;
   endtask

   task automatic shift_in_bit(input logic b);
      acc_bits[acc_count] = b;
      acc_count++;
      if (acc_count == 8) begin
         emit_word(acc_bits, 1'b0);
         acc_bits = '0;
         acc_count = 0;
      end
   endtask

   task automatic encode_gamma(input logic [31:0] value, input logic last);
      int top;
      int before_count;
      before_count = expected_words.size();
      if (dropping) begin
         if (last) begin
            dropping = 1'b0;
         end
         return;
      end
      if (value == '0 || value > igam_pkg::ValueMax) begin
         acc_bits = '0;
         acc_count = 0;
         emit_word(8'h00, 1'b1);
         block_bytes = 0;
         dropping = !last;
         return;
      end
      top = 0;
      for (int k = 0; k <= 30; k++) begin
         if (value[k]) begin
            top = k;
         end
      end
      for (int k = 0; k < top; k++) begin
         shift_in_bit(1'b0);
         shift_in_bit(value[k]);
      end
      shift_in_bit(1'b1);
      if (last) begin
         if (acc_count != 0) begin
            emit_word(acc_bits, 1'b0);
            acc_bits = '0;
            acc_count = 0;
         end
         // marker byte when the block ends on a whole word
         if (comp_mode == ModeMarker && block_bytes == 0) begin
            emit_word(8'h00, 1'b0);
         end
         if (expected_words.size() > before_count) begin
            expected_words[expected_words.size()-1].eob = 1'b1;
         end
         block_bytes = 0;
      end
   endtask

   task automatic send_value(input logic [31:0] value, input logic last);
      if (src_gaps && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      values_sent++;
      encode_gamma(value, last);
   endtask

   // drop valid and wait out every expected word plus the pipeline tail
   task automatic drain;
      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_mode(input bit mode);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= mode;
      @(posedge clock);
      csr_we <= 1'b0;
      comp_mode = mode;
   endtask

   function automatic logic [31:0] pick_value(input int err_pct);
      int top;
      logic [31:0] v;
      if ($urandom_range(0, 99) < err_pct) begin
         case ($urandom_range(0, 3))
            0: v = '0;
            1: v = $urandom | 32'h8000_0000;
            2: v = igam_pkg::ValueMax + 32'd1 + $urandom_range(0, 32'h3FFF_FFFE);
            default: v = $urandom;
         endcase
      end else begin
         top = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 6) : $urandom_range(0, 30);
         if (top == 30) begin
            v = igam_pkg::ValueMax;
         end else begin
            v = (32'd1 << top) | ($urandom & ((32'd1 << top) - 32'd1));
         end
      end
      return v;
   endfunction

   task automatic send_block(input int len, input int err_pct);
      for (int i = 0; i < len; i++) begin
         send_value(pick_value(err_pct), i == len - 1);
      end
   endtask

   task automatic random_run(input int n_items, input int err_pct);
      int done;
      int len;
      done = 0;
      while (done < n_items) begin
         len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
         send_block(len, err_pct);
         done += len;
      end
   endtask

   // whole-word block: 61 + 3 code bits fill exactly eight bytes
   task automatic send_word_aligned_block;
      send_value(igam_pkg::ValueMax, 1'b0);
      send_value(32'd1, 1'b0);
      send_value(32'd1, 1'b0);
      send_value(32'd1, 1'b1);
   endtask

   task automatic test_directed;
      send_value(32'd1, 1'b1);
      send_value(32'd2, 1'b0);
      send_value(32'd3, 1'b0);
      send_value(32'h3FFF_FFFF, 1'b0);
      send_value(32'h2AAA_AAAA, 1'b0);
      send_value(32'h1555_5555, 1'b0);
      send_value(igam_pkg::ValueMax, 1'b1);
      send_word_aligned_block();
      // error mid-block, then drop through the block end
      send_value(32'd7, 1'b0);
      send_value(32'd0, 1'b0);
      send_value(32'd9, 1'b0);
      send_value(32'h7FFF_FFFF, 1'b0);
      send_value(32'd4, 1'b1);
      send_value(32'd6, 1'b1);
      // error on the block's last value leaves nothing to drop
      send_value(32'h8000_0000, 1'b1);
      send_value(32'h4000_0001, 1'b1);
      send_value(32'hFFFF_FFFF, 1'b0);
      send_value(32'd1, 1'b1);
      drain();
   endtask

   task automatic test_component_mode;
      set_mode(ModeComponent);
      send_word_aligned_block();
      random_run(100, 6);
      set_mode(ModeMarker);
      send_word_aligned_block();
      random_run(120, 6);
      drain();
   endtask

   task automatic test_backpressure;
      hold_req = 300;
      send_block(40, 0);
      drain();
   endtask

   task automatic test_sender_pause;
      send_block(8, 10);
      drain();
      set_mode(ModeComponent);
      send_block(8, 0);
      set_mode(ModeMarker);
      send_block(8, 10);
      drain();
   endtask

   task automatic test_no_idling;
      src_gaps = 1'b0;
      sink_gaps = 1'b0;
      random_run(60, 5);
      drain();
   endtask

   always @(posedge clock) begin
      code_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word data=%02h last=%b user=%b",
                                      rsp_tdata, rsp_tlast, rsp_tuser));
         end else begin
            want = expected_words.pop_front();
            if (rsp_tdata !== want.data) begin
               report_mismatch($sformatf("out_byte %02h, want %02h", rsp_tdata, want.data));
            end
            if (rsp_tlast !== want.eob) begin
               report_mismatch($sformatf("end_of_block %b, want %b", rsp_tlast, want.eob));
            end
            if (rsp_tuser !== want.err) begin
               report_mismatch($sformatf("error %b, want %b", rsp_tuser, want.err));
            end
         end
         if (rsp_tuser === 1'b1) begin
            error_words++;
         end
         words_seen++;
      end
      if (hold_req != 0) begin
         hold_cnt = hold_req;
         hold_req = 0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_tready <= 1'b0;
      end else if (gap_cnt > 0) begin
         gap_cnt--;
         rsp_tready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
         gap_cnt = $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      quiet_cycles = 0;
      while (quiet_cycles < StallLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("watchdog: no word moved for %0d cycles, %0d words still expected",
               StallLimit, expected_words.size());
      $display("FAILURE");
      $finish;
   end

   initial begin
      acc_bits = '0;
      acc_count = 0;
      block_bytes = 0;
      dropping = 1'b0;
      comp_mode = ModeMarker;
      fail_count = 0;
      values_sent = 0;
      words_seen = 0;
      error_words = 0;
      hold_req = 0;
      hold_cnt = 0;
      gap_cnt = 0;
      src_gaps = 1'b1;
      sink_gaps = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_component_mode();
      test_backpressure();
      test_sender_pause();
      test_no_idling();
      $display("ran %0d values into %0d code words (%0d error words)",
               values_sent, words_seen, error_words);
      $display("both marker settings, drop-to-block-end, long output hold and idle gaps");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
`default_nettype wire

### sim.f
design/igam_pkg.sv
design/igam_in_reg.sv
design/igam_code.sv
design/igam_packer.sv
design/interleaved_gamma_encoder.sv
tb/tb_top.sv
